>>> hdl/bitmap_page_allocator_assert.svh
// assertion macros shared by the bitmap page allocator rtl
`ifndef BITMAP_PAGE_ALLOCATOR_ASSERT_SVH
`define BITMAP_PAGE_ALLOCATOR_ASSERT_SVH

// same-cycle implication, checked on clk, off during reset
`define BPA_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on clk, off during reset
`define BPA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/bpa_pkg.sv
// types and constants of the bitmap page allocator
package bpa_pkg;

	// map words hold 64 page bits each
	localparam int WORD_BITS  = 64;
	localparam int BIT_W      = 6;
	// page limits are at most 2^20, held in 21 bits
	localparam int LIM_W      = 21;
	localparam int CNT_W      = 13;
	localparam int PAGE_SHIFT = 12;
	// pages in the first megabyte
	localparam int LOW_PAGES  = 256;
	localparam logic [31:0] KEND_RESET = 32'h0010_0000;

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [LIM_W-1:0]     lim_t;
	typedef logic [CNT_W-1:0]     cnt_t;

	typedef enum logic [1:0] {
		ACT_INIT  = 2'd0,
		ACT_ALLOC = 2'd1,
		ACT_FREE  = 2'd2,
		ACT_NOP   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		STAT_DONE    = 2'd0,
		STAT_OOM     = 2'd1,
		STAT_IGNORED = 2'd2
	} status_t;

endpackage

>>> hdl/bpa_ram.sv
// generic simple dual-port ram with registered read
module bpa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> hdl/bitmap_page_allocator.sv
// first-fit bitmap page allocator, top level
//
// Usage: an item (action, free_address) is taken on a rising edge with start high and
// busy low. Exactly one result follows: page_address, status, used_count and free_count
// are valid for the single cycle in which done is high; the receiver cannot hold it off.
// The used map sits in one RAM of 64-bit words, DEPTH words (64 for the defaults).
// How each item runs from the accepting edge to the done cycle:
//   init  : the sweep rewrites one map word per cycle over all DEPTH words
//   alloc : one word read per cycle until the first free bit or the last word
//   free  : read, then write back; a page out of range finishes with no map access
//   code 3: finishes with no map access
// One item is in flight at a time; busy stays high until its result is shown.
// The kernel end address is written over the APB port (address 0); the user must write it
// only while the block is idle, which the block does not enforce. After reset the block
// sweeps the RAM clearing every word, with busy high; APB writes are taken during that
// pass. Reset also zeroes the used count and sets the kernel end address to 1 MB.
`include "bitmap_page_allocator_assert.svh"

module bitmap_page_allocator #(
	parameter int PAGE_COUNT = 4096,
	parameter int MAP_BYTES  = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	// item channel
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  action,
	input  logic [31:0] free_address,
	// result channel
	output logic        done,
	output logic [31:0] page_address,
	output logic [1:0]  status,
	output logic [12:0] used_count,
	output logic [12:0] free_count,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int WB         = bpa_pkg::WORD_BITS;
	localparam int BW         = bpa_pkg::BIT_W;
	localparam int HELD       = (PAGE_COUNT < MAP_BYTES * 8) ? PAGE_COUNT : MAP_BYTES * 8;
	localparam int DEPTH      = (HELD + WB - 1) / WB;
	localparam int AW         = $clog2(DEPTH);
	localparam int LAST_VALID = HELD - (DEPTH - 1) * WB;
	localparam bpa_pkg::word_t LAST_MASK = (LAST_VALID == WB) ? {WB{1'b1}} :
		((bpa_pkg::word_t'(1) << LAST_VALID) - bpa_pkg::word_t'(1));
	localparam bpa_pkg::lim_t HELD_LIM  = bpa_pkg::lim_t'(HELD);
	localparam bpa_pkg::cnt_t HELD_CNT  = bpa_pkg::cnt_t'(HELD);
	localparam logic [AW:0]   DEPTH_CNT = (AW + 1)'(DEPTH);
	localparam logic [AW:0]   LAST_CNT  = (AW + 1)'(DEPTH - 1);
	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SWEEP,
		ST_SCAN,
		ST_FREE
	} state_t;

	state_t               state_q;
	logic [AW:0]          sweep_addr_q;
	logic [AW:0]          scan_addr_q;
	bpa_pkg::lim_t        limit_q;
	logic                 valid_s1;
	logic [AW-1:0]        addr_s1;
	logic [BW-1:0]        bit_s1;
	bpa_pkg::cnt_t        used_q;
	logic [31:0]          kend_q;
	logic                 done_q;
	logic [31:0]          page_address_q;
	bpa_pkg::status_t     status_q;

	logic                 accept;
	logic                 cfg_write;
	logic [19:0]          free_page;
	logic                 free_in_range;
	logic [AW-1:0]        free_word;
	bpa_pkg::lim_t        kern_pages;
	bpa_pkg::lim_t        init_limit;
	bpa_pkg::lim_t        sweep_base;
	bpa_pkg::lim_t        sweep_span;
	bpa_pkg::word_t       sweep_word;
	bpa_pkg::word_t       scan_word;
	logic                 scan_found;
	logic [BW-1:0]        scan_bit;
	logic                 scan_issue;

	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	bpa_pkg::word_t       ram_wdata;
	logic                 ram_re;
	logic [AW-1:0]        ram_raddr;
	bpa_pkg::word_t       ram_rdata;

	// handshakes and configuration readback
	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
	assign prdata    = (paddr[2] == 1'b0) ? kend_q : 32'd0;

	// result ports
	assign done         = done_q;
	assign page_address = page_address_q;
	assign status       = status_q;
	assign used_count   = used_q;
	assign free_count   = HELD_CNT - used_q;

	// page addressed by a free item
	assign free_page     = free_address[31:bpa_pkg::PAGE_SHIFT];
	assign free_in_range = (bpa_pkg::lim_t'(free_page) < HELD_LIM);
	assign free_word     = free_page[BW +: AW];

	// init limit: max of low memory and kernel end page, clamped to the held pages
	always_comb begin
		kern_pages = bpa_pkg::lim_t'(kend_q[31:bpa_pkg::PAGE_SHIFT]) + bpa_pkg::lim_t'(1);
		init_limit = kern_pages;
		if (kern_pages < bpa_pkg::lim_t'(bpa_pkg::LOW_PAGES)) begin
			init_limit = bpa_pkg::lim_t'(bpa_pkg::LOW_PAGES);
		end
		if (init_limit > HELD_LIM) begin
			init_limit = HELD_LIM;
		end
	end

	// map word written by the sweep: bits below the limit set
	always_comb begin
		sweep_base = bpa_pkg::lim_t'({sweep_addr_q[AW-1:0], {BW{1'b0}}});
		sweep_span = limit_q - sweep_base;
		if (limit_q >= sweep_base + bpa_pkg::lim_t'(WB)) begin
			sweep_word = {WB{1'b1}};
		end else if (limit_q > sweep_base) begin
			sweep_word = (bpa_pkg::word_t'(1) << sweep_span[BW-1:0]) - bpa_pkg::word_t'(1);
		end else begin
			sweep_word = '0;
		end
	end

	// first free bit of the word read back, pages past the end count as used
	always_comb begin
		scan_word = ram_rdata;
		if (addr_s1 == LAST_ADDR) begin
			scan_word = ram_rdata | ~LAST_MASK;
		end
		scan_found = ~&scan_word;
		scan_bit   = '0;
		for (int i = WB - 1; i >= 0; i--) begin
			if (!scan_word[i]) begin
				scan_bit = BW'(i);
			end
		end
	end

	assign scan_issue = (scan_addr_q != DEPTH_CNT);

	// ram access per state
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_s1;
		ram_wdata = ram_rdata;
		ram_re    = 1'b0;
		ram_raddr = scan_addr_q[AW-1:0];
		case (state_q)
			ST_CLEAR, ST_SWEEP: begin
				ram_we    = 1'b1;
				ram_waddr = sweep_addr_q[AW-1:0];
				ram_wdata = sweep_word;
			end
			ST_IDLE: begin
				ram_re    = accept && (action == bpa_pkg::ACT_FREE) && free_in_range;
				ram_raddr = free_word;
			end
			ST_SCAN: begin
				ram_re    = scan_issue;
				ram_we    = valid_s1 && scan_found;
				ram_wdata = ram_rdata | (bpa_pkg::word_t'(1) << scan_bit);
			end
			ST_FREE: begin
				ram_we    = ram_rdata[bit_s1];
				ram_wdata = ram_rdata & ~(bpa_pkg::word_t'(1) << bit_s1);
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	bpa_ram #(
		.WIDTH (WB),
		.DEPTH (DEPTH)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// sequencer, counters, configuration and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			sweep_addr_q   <= '0;
			scan_addr_q    <= '0;
			limit_q        <= '0;
			valid_s1       <= 1'b0;
			addr_s1        <= '0;
			bit_s1         <= '0;
			used_q         <= '0;
			kend_q         <= bpa_pkg::KEND_RESET;
			done_q         <= 1'b0;
			page_address_q <= '0;
			status_q       <= bpa_pkg::STAT_DONE;
		end else begin
			done_q <= 1'b0;
			if (cfg_write) begin
				kend_q <= pwdata;
			end
			case (state_q)
				ST_CLEAR, ST_SWEEP: begin
					sweep_addr_q <= sweep_addr_q + 1'b1;
					if (sweep_addr_q == LAST_CNT) begin
						state_q <= ST_IDLE;
						if (state_q == ST_SWEEP) begin
							done_q         <= 1'b1;
							page_address_q <= '0;
							status_q       <= bpa_pkg::STAT_DONE;
							used_q         <= limit_q[bpa_pkg::CNT_W-1:0];
						end
					end
				end
				ST_IDLE: begin
					if (accept) begin
						case (bpa_pkg::action_t'(action))
							bpa_pkg::ACT_INIT: begin
								limit_q      <= init_limit;
								sweep_addr_q <= '0;
								state_q      <= ST_SWEEP;
							end
							bpa_pkg::ACT_ALLOC: begin
								scan_addr_q <= '0;
								valid_s1    <= 1'b0;
								state_q     <= ST_SCAN;
							end
							bpa_pkg::ACT_FREE: begin
								if (free_in_range) begin
									addr_s1 <= free_word;
									bit_s1  <= free_page[BW-1:0];
									state_q <= ST_FREE;
								end else begin
									done_q         <= 1'b1;
									page_address_q <= '0;
									status_q       <= bpa_pkg::STAT_IGNORED;
								end
							end
							default: begin
								done_q         <= 1'b1;
								page_address_q <= '0;
								status_q       <= bpa_pkg::STAT_DONE;
							end
						endcase
					end
				end
				ST_SCAN: begin
					// stale pipeline flag is cleared again when the next alloc is taken
					valid_s1 <= scan_issue;
					addr_s1  <= scan_addr_q[AW-1:0];
					if (scan_issue) begin
						scan_addr_q <= scan_addr_q + 1'b1;
					end
					if (valid_s1) begin
						if (scan_found) begin
							done_q         <= 1'b1;
							page_address_q <= 32'({addr_s1, scan_bit,
								{bpa_pkg::PAGE_SHIFT{1'b0}}});
							status_q       <= bpa_pkg::STAT_DONE;
							used_q         <= used_q + 1'b1;
							state_q        <= ST_IDLE;
						end else if (addr_s1 == LAST_ADDR) begin
							done_q         <= 1'b1;
							page_address_q <= '0;
							status_q       <= bpa_pkg::STAT_OOM;
							state_q        <= ST_IDLE;
						end
					end
				end
				ST_FREE: begin
					done_q         <= 1'b1;
					page_address_q <= '0;
					if (ram_rdata[bit_s1]) begin
						used_q   <= used_q - 1'b1;
						status_q <= bpa_pkg::STAT_DONE;
					end else begin
						status_q <= bpa_pkg::STAT_IGNORED;
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// checks on the sequencer
	`BPA_ASSERT_SAME(a_done_when_idle, done_q, state_q == ST_IDLE, "result shown while busy")
	`BPA_ASSERT_SAME(a_no_write_idle, state_q == ST_IDLE, !ram_we, "map written while idle")
	`BPA_ASSERT_NEXT(a_item_progress, accept, busy || done_q, "accepted item dropped")
	`BPA_ASSERT_SAME(a_oom_zero_addr, done_q && (status_q != bpa_pkg::STAT_DONE),
		page_address_q == 32'd0, "failed item returned a page address")

endmodule

>>> test/tb.sv
// testbench for the bitmap page allocator: directed and random items checked against a predictor
module tb;

	localparam int HELD_PAGES = 4096;
	localparam int CYCLE_LIMIT = 500000;
	localparam logic [2:0] REG_KEND = 3'd0;

	typedef struct packed {
		logic [31:0]      page_address;
		bpa_pkg::status_t status;
		bpa_pkg::cnt_t    used_count;
		bpa_pkg::cnt_t    free_count;
	} page_result_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  action;
	logic [31:0] free_address;
	logic        done;
	logic [31:0] page_address;
	logic [1:0]  status;
	logic [12:0] used_count;
	logic [12:0] free_count;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// predictor state
	logic [HELD_PAGES-1:0] page_map = '0;
	int unsigned           pages_used = 0;
	logic [31:0]           kend_model = bpa_pkg::KEND_RESET;

	page_result_t  pending_results[$];
	page_result_t  oldest_result;
	int unsigned   granted_pages[$];
	int            mismatch_count = 0;
	int unsigned   cycle_count = 0;
	int            burst_left = 0;

	bitmap_page_allocator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.action       (action),
		.free_address (free_address),
		.done         (done),
		.page_address (page_address),
		.status       (status),
		.used_count   (used_count),
		.free_count   (free_count),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #1 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic flag_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("mismatch on %s: expected %h, got %h", what, want, got);
	endtask

	// first-fit allocator behaviour, one item at a time
	function automatic page_result_t predict_page_step(input bpa_pkg::action_t act,
			input logic [31:0] addr);
		page_result_t r;
		int unsigned  reserve_pages;
		int unsigned  pg;
		r.page_address = '0;
		r.status = bpa_pkg::STAT_DONE;
		case (act)
			bpa_pkg::ACT_INIT: begin
				// reserve the low megabyte or up to the kernel end page, whichever is larger
				reserve_pages = (kend_model >> bpa_pkg::PAGE_SHIFT) + 1;
				if (reserve_pages < bpa_pkg::LOW_PAGES)
					reserve_pages = bpa_pkg::LOW_PAGES;
				if (reserve_pages > HELD_PAGES)
					reserve_pages = HELD_PAGES;
				page_map = '0;
				for (pg = 0; pg < reserve_pages; pg++)
					page_map[pg] = 1'b1;
				pages_used = reserve_pages;
			end
			bpa_pkg::ACT_ALLOC: begin
				r.status = bpa_pkg::STAT_OOM;
				for (pg = 0; pg < HELD_PAGES; pg++) begin
					if (!page_map[pg]) begin
						page_map[pg] = 1'b1;
						pages_used++;
						r.page_address = pg << bpa_pkg::PAGE_SHIFT;
						r.status = bpa_pkg::STAT_DONE;
						break;
					end
				end
			end
			bpa_pkg::ACT_FREE: begin
				pg = addr >> bpa_pkg::PAGE_SHIFT;
				if (pg < HELD_PAGES && page_map[pg]) begin
					page_map[pg] = 1'b0;
					pages_used--;
				end else begin
					r.status = bpa_pkg::STAT_IGNORED;
				end
			end
			default: ;
		endcase
		r.used_count = bpa_pkg::cnt_t'(pages_used);
		r.free_count = bpa_pkg::cnt_t'(HELD_PAGES - pages_used);
		return r;
	endfunction

	// present one item, predict it once taken, then pace the sender in bursts
	task automatic send_item(input bpa_pkg::action_t act, input logic [31:0] addr);
		page_result_t r;
		int           gap;
		start <= 1'b1;
		action <= act;
		free_address <= addr;
		do @(posedge clk); while (busy);
		r = predict_page_step(act, addr);
		pending_results.push_back(r);
		if (act == bpa_pkg::ACT_INIT)
			granted_pages.delete();
		else if (act == bpa_pkg::ACT_ALLOC && r.status == bpa_pkg::STAT_DONE)
			granted_pages.push_back(r.page_address >> bpa_pkg::PAGE_SHIFT);
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
			if (gap != 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// hold off until every outstanding item has come back
	task automatic drain_results();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// one register transfer, setup then access, followed by a return to idle
	task automatic apb_transfer(input logic is_write, input logic [31:0] wdata,
			output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= is_write;
		paddr <= REG_KEND;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_kend(input logic [31:0] value);
		logic [31:0] rdata;
		apb_transfer(1'b1, value, rdata);
		kend_model = value;
		apb_transfer(1'b0, '0, rdata);
		if (rdata !== value)
			flag_mismatch("kernel end readback", value, rdata);
	endtask

	// result checking against the oldest prediction
	always @(posedge clk) begin
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (pending_results.size() == 0) begin
				flag_mismatch("unexpected result page_address", '0, page_address);
			end else begin
				oldest_result = pending_results.pop_front();
				if (page_address !== oldest_result.page_address)
					flag_mismatch("page_address", oldest_result.page_address, page_address);
				if (status !== oldest_result.status)
					flag_mismatch("status", oldest_result.status, status);
				if (used_count !== oldest_result.used_count)
					flag_mismatch("used_count", oldest_result.used_count, used_count);
				if (free_count !== oldest_result.free_count)
					flag_mismatch("free_count", oldest_result.free_count, free_count);
			end
		end
	end

	// map still clear from reset: alloc hands out page 0, unused code, frees
	task automatic test_before_init();
		logic [31:0] rdata;
		apb_transfer(1'b0, '0, rdata);
		if (rdata !== bpa_pkg::KEND_RESET)
			flag_mismatch("kernel end after reset", bpa_pkg::KEND_RESET, rdata);
		send_item(bpa_pkg::ACT_ALLOC, 32'h0);
		send_item(bpa_pkg::ACT_NOP, 32'hFFFF_FFFF);
		send_item(bpa_pkg::ACT_FREE, 32'h0000_0FFF);
		send_item(bpa_pkg::ACT_FREE, 32'h0000_0000);
		send_item(bpa_pkg::ACT_FREE, 32'hFFFF_FFFF);
		drain_results();
	endtask

	// reserved region at the default, the lowest and the highest kernel end
	task automatic test_init_bounds();
		send_item(bpa_pkg::ACT_INIT, 32'h0);
		send_item(bpa_pkg::ACT_ALLOC, 32'h0);
		drain_results();
		set_kend(32'h0000_0000);
		send_item(bpa_pkg::ACT_INIT, 32'h0);
		send_item(bpa_pkg::ACT_ALLOC, 32'h0);
		send_item(bpa_pkg::ACT_FREE, 32'h0010_0000);
		drain_results();
		set_kend(32'hFFFF_FFFF);
		send_item(bpa_pkg::ACT_INIT, 32'h0);
		send_item(bpa_pkg::ACT_ALLOC, 32'h0);
		send_item(bpa_pkg::ACT_NOP, 32'h0);
		drain_results();
	endtask

	// last page of the map, out of memory and the first page past the end
	task automatic test_page_limits();
		set_kend(32'h00FF_E000);
		send_item(bpa_pkg::ACT_INIT, 32'h0);
		send_item(bpa_pkg::ACT_ALLOC, 32'h0);
		send_item(bpa_pkg::ACT_ALLOC, 32'h0);
		send_item(bpa_pkg::ACT_FREE, 32'h00FF_FFFF);
		send_item(bpa_pkg::ACT_FREE, 32'h0100_0000);
		send_item(bpa_pkg::ACT_ALLOC, 32'h0);
		drain_results();
	endtask

	// random mixes under several kernel end settings
	task automatic test_random_traffic();
		logic [31:0] kend;
		logic [31:0] addr;
		int unsigned pick;
		int unsigned slot;
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: kend = $urandom_range(0, 32'h0020_0000);
				1: kend = 32'h0000_0000;
				2: kend = 32'h00FF_E000;
				3: kend = $urandom;
				4: kend = $urandom_range(0, 32'h00FF_FFFF);
				default: kend = bpa_pkg::KEND_RESET;
			endcase
			drain_results();
			set_kend(kend);
			send_item(bpa_pkg::ACT_INIT, $urandom);
			for (int n = 0; n < 74; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 40) begin
					send_item(bpa_pkg::ACT_ALLOC, $urandom);
				end else if (pick < 75) begin
					// give back a page that was handed out
					if (granted_pages.size() != 0) begin
						slot = $urandom_range(0, granted_pages.size() - 1);
						addr = (granted_pages[slot] << bpa_pkg::PAGE_SHIFT) |
							$urandom_range(0, 4095);
						granted_pages.delete(slot);
					end else begin
						addr = $urandom_range(0, 32'h00FF_FFFF);
					end
					send_item(bpa_pkg::ACT_FREE, addr);
				end else if (pick < 85) begin
					send_item(bpa_pkg::ACT_FREE, $urandom_range(0, 32'h00FF_FFFF));
				end else if (pick < 92) begin
					send_item(bpa_pkg::ACT_FREE, $urandom);
				end else if (pick < 96) begin
					send_item(bpa_pkg::ACT_INIT, $urandom);
				end else begin
					send_item(bpa_pkg::ACT_NOP, $urandom);
				end
				if ($urandom_range(0, 49) == 0)
					drain_results();
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		action <= bpa_pkg::ACT_INIT;
		free_address <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_before_init();
		test_init_bounds();
		test_page_limits();
		test_random_traffic();

		drain_results();
		repeat (80) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

>>> filelist.f
+incdir+hdl
hdl/bpa_pkg.sv
hdl/bpa_ram.sv
hdl/bitmap_page_allocator.sv
test/tb.sv
